### rtl/kbd_pkg.sv
// shared types, constants and keymap rom functions for the scancode decoder
// no dependencies; used by every file in rtl
package kbd_pkg;

	// led command queue
	localparam int CMD_QUEUE_DEPTH = 32;
	localparam int QPTR_W = $clog2(CMD_QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

	// scancodes and keyboard commands
	localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2a;
	localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BREAK = 8'haa;
	localparam logic [7:0] SC_RSHIFT_BREAK = 8'hb6;
	localparam logic [7:0] SC_CAPS         = 8'h3a;
	localparam logic [7:0] SC_NUM          = 8'h45;
	localparam logic [7:0] SC_SCROLL       = 8'h46;
	localparam logic [7:0] SC_ACK          = 8'hfa;
	localparam logic [7:0] SC_RESEND       = 8'hfe;
	localparam logic [7:0] LED_CMD         = 8'hed;
	localparam logic [7:0] CASE_OFFSET     = 8'h20;
	localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z    = 8'h5a;

	// led mask bits
	localparam logic [2:0] LED_SCROLL = 3'b001;
	localparam logic [2:0] LED_NUM    = 3'b010;
	localparam logic [2:0] LED_CAPS   = 3'b100;

	// result kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_CMD  = 1'b1;

	// one queue entry: the 0xed command plus its led mask, or the command alone
	typedef struct packed {
		logic       has_mask;
		logic [2:0] mask;
	} qent_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] value;
		logic       last;
	} result_t;

	// results of one item handed to the output buffer
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} res_push_t;

	function automatic logic [7:0] keymap_plain(input logic [6:0] c);
		logic [7:0] ch;
		unique case (c)
			7'h02: ch = 8'h31;
			7'h03: ch = 8'h32;
			7'h04: ch = 8'h33;
			7'h05: ch = 8'h34;
			7'h06: ch = 8'h35;
			7'h07: ch = 8'h36;
			7'h08: ch = 8'h37;
			7'h09: ch = 8'h38;
			7'h0a: ch = 8'h39;
			7'h0b: ch = 8'h30;
			7'h0c: ch = 8'h2d;
			7'h0d: ch = 8'h5e;
			7'h0e: ch = 8'h08;
			7'h10: ch = 8'h51;
			7'h11: ch = 8'h57;
			7'h12: ch = 8'h45;
			7'h13: ch = 8'h52;
			7'h14: ch = 8'h54;
			7'h15: ch = 8'h59;
			7'h16: ch = 8'h55;
			7'h17: ch = 8'h49;
			7'h18: ch = 8'h4f;
			7'h19: ch = 8'h50;
			7'h1a: ch = 8'h40;
			7'h1b: ch = 8'h5b;
			7'h1c: ch = 8'h0a;
			7'h1e: ch = 8'h41;
			7'h1f: ch = 8'h53;
			7'h20: ch = 8'h44;
			7'h21: ch = 8'h46;
			7'h22: ch = 8'h47;
			7'h23: ch = 8'h48;
			7'h24: ch = 8'h4a;
			7'h25: ch = 8'h4b;
			7'h26: ch = 8'h4c;
			7'h27: ch = 8'h3b;
			7'h28: ch = 8'h3a;
			7'h2b: ch = 8'h5d;
			7'h2c: ch = 8'h5a;
			7'h2d: ch = 8'h58;
			7'h2e: ch = 8'h43;
			7'h2f: ch = 8'h56;
			7'h30: ch = 8'h42;
			7'h31: ch = 8'h4e;
			7'h32: ch = 8'h4d;
			7'h33: ch = 8'h2c;
			7'h34: ch = 8'h2e;
			7'h35: ch = 8'h2f;
			7'h37: ch = 8'h2a;
			7'h39: ch = 8'h20;
			7'h47: ch = 8'h37;
			7'h48: ch = 8'h38;
			7'h49: ch = 8'h39;
			7'h4a: ch = 8'h2d;
			7'h4b: ch = 8'h34;
			7'h4c: ch = 8'h35;
			7'h4d: ch = 8'h36;
			7'h4e: ch = 8'h2b;
			7'h4f: ch = 8'h31;
			7'h50: ch = 8'h32;
			7'h51: ch = 8'h33;
			7'h52: ch = 8'h30;
			7'h53: ch = 8'h2e;
			7'h73: ch = 8'h5c;
			7'h7d: ch = 8'h5c;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// shifted map differs from the plain map only on these keys
	function automatic logic [7:0] keymap_shifted(input logic [6:0] c);
		logic [7:0] ch;
		unique case (c)
			7'h02: ch = 8'h21;
			7'h03: ch = 8'h22;
			7'h04: ch = 8'h23;
			7'h05: ch = 8'h24;
			7'h06: ch = 8'h25;
			7'h07: ch = 8'h26;
			7'h08: ch = 8'h27;
			7'h09: ch = 8'h28;
			7'h0a: ch = 8'h29;
			7'h0b: ch = 8'h7e;
			7'h0c: ch = 8'h3d;
			7'h0d: ch = 8'h7e;
			7'h1a: ch = 8'h60;
			7'h1b: ch = 8'h7b;
			7'h27: ch = 8'h2b;
			7'h28: ch = 8'h2a;
			7'h2b: ch = 8'h7d;
			7'h33: ch = 8'h3c;
			7'h34: ch = 8'h3e;
			7'h35: ch = 8'h3f;
			7'h73: ch = 8'h5f;
			7'h7d: ch = 8'h7c;
			default: ch = keymap_plain(c);
		endcase
		return ch;
	endfunction

endpackage

### rtl/kbd_res_fifo.sv
// four-entry result buffer between the decoder and the result channel
// depends on kbd_pkg (result_t, res_push_t)
module kbd_res_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  kbd_pkg::res_push_t push,
	output logic               busy,
	output logic               res_valid,
	input  logic               res_stall,
	output kbd_pkg::result_t   res
);

	kbd_pkg::result_t buf_q [4];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign res_valid = (cnt_q != 3'd0);
	assign res       = buf_q[rp_q];
	assign pop       = res_valid && !res_stall;
	// room for two results must remain before another item is taken
	assign busy      = (cnt_q > 3'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wp_q  <= wp_q + push.n;
			rp_q  <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push.n} - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			buf_q[wp_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			buf_q[wp_q + 2'd1] <= push.r1;
		end
	end

endmodule

### rtl/keyboard_scancode_decoder.sv
// set-1 scancode decoder with shift/lock tracking and led command queue
// depends on kbd_pkg and kbd_res_fifo
//
// usage:
//   scan channel (scan_valid/scan_stall/scancode) takes one raw keyboard byte
//   per item: make and break codes, ack 0xfa and resend 0xfe.
//   res channel (res_valid/res_stall/kind/value/last) gives zero, one or two
//   result items per input item: a host character (kind 0) and/or a command
//   byte for the keyboard (kind 1); last marks the final result of an item.
// buffering: the results of an item are written into the result buffer when it is
//   accepted and reach the res ports from that buffer in order.
// throughput: one item per cycle while scan_stall is low; every item is decoded in the
//   cycle it is accepted, the queue head being prefetched from the queue memory.
//   an item with two results gives them one after the other on the res port, so the
//   sustained rate follows how fast results are drained.
// stall: results collect in a four-entry buffer; scan_stall rises while that
//   buffer holds more than two results and drops as res_stall lets it drain.
// reset: arst_n clears the shift flags, leds, queue pointers and counts, the
//   pending-ack flag and the held command; queue memory is not cleared and
//   needs no clearing pass.
module keyboard_scancode_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       scan_valid,
	output logic       scan_stall,
	input  logic [7:0] scancode,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       kind,
	output logic [7:0] value,
	output logic       last
);

	localparam logic [kbd_pkg::QPTR_W-1:0] PTR_LAST =
		kbd_pkg::QPTR_W'(kbd_pkg::CMD_QUEUE_DEPTH - 1);
	localparam logic [kbd_pkg::QCNT_W-1:0] CNT_PAIR_MAX =
		kbd_pkg::QCNT_W'(kbd_pkg::CMD_QUEUE_DEPTH - 2);
	localparam logic [kbd_pkg::QCNT_W-1:0] CNT_SINGLE =
		kbd_pkg::QCNT_W'(kbd_pkg::CMD_QUEUE_DEPTH - 1);

	// architectural state
	logic [1:0]                  shift_q;     // bit0 left, bit1 right
	logic [2:0]                  leds_q;      // bit0 scroll, bit1 num, bit2 caps
	logic                        await_q;     // a sent command waits for ack
	logic [7:0]                  held_q;      // last command sent, for resend
	logic [kbd_pkg::QPTR_W-1:0]  rp_q;        // head entry of the queue memory
	logic [kbd_pkg::QPTR_W-1:0]  wp_q;        // next free entry
	logic [kbd_pkg::QCNT_W-1:0]  cnt_q;       // command bytes queued
	logic                        half_q;      // head entry already sent its 0xed

	// queue memory: one entry per queued lock press, for 0xed and, if it fit, the led mask
	kbd_pkg::qent_t              qmem [kbd_pkg::CMD_QUEUE_DEPTH];
	kbd_pkg::qent_t              head_q;      // prefetched mem[rp]
	logic [kbd_pkg::QPTR_W-1:0]  rd_addr;
	logic                        qwe;
	kbd_pkg::qent_t              qwd;

	logic                        accept;
	logic [7:0]                  ch_map;
	logic [7:0]                  ch;
	logic                        char_v;
	logic                        letter;
	logic [2:0]                  lock_bit;
	logic [2:0]                  leds_n;
	logic [1:0]                  shift_n;
	logic                        await_a;
	logic                        resend_v;
	logic                        push_pair;
	logic                        push_single;
	logic [kbd_pkg::QCNT_W-1:0]  cnt_a;
	logic                        pop_v;
	kbd_pkg::qent_t              head;
	logic [7:0]                  pop_byte;
	logic                        pop_adv;
	logic [kbd_pkg::QPTR_W-1:0]  rp_inc;
	logic [kbd_pkg::QPTR_W-1:0]  wp_inc;
	logic [kbd_pkg::QPTR_W-1:0]  rp_n;
	kbd_pkg::result_t            r_first;
	kbd_pkg::result_t            r_pop;
	kbd_pkg::res_push_t          push;
	logic                        fifo_busy;
	kbd_pkg::result_t            res;

	assign scan_stall = fifo_busy;
	assign accept     = scan_valid && !scan_stall;

	// character lookup; letters come out lower case unless caps xor shift
	assign ch_map = (shift_q != 2'b00) ? kbd_pkg::keymap_shifted(scancode[6:0])
	                                   : kbd_pkg::keymap_plain(scancode[6:0]);
	assign letter = (ch_map >= kbd_pkg::CHAR_UPPER_A) && (ch_map <= kbd_pkg::CHAR_UPPER_Z);
	assign ch     = (letter && (leds_q[2] == (shift_q != 2'b00)))
	              ? ch_map + kbd_pkg::CASE_OFFSET : ch_map;
	// codes with the top bit set are breaks or replies, never characters
	assign char_v = !scancode[7] && (ch != 8'h00);

	always_comb begin
		shift_n  = shift_q;
		lock_bit = 3'b000;
		unique case (scancode)
			kbd_pkg::SC_LSHIFT_MAKE:  shift_n = shift_q | 2'b01;
			kbd_pkg::SC_RSHIFT_MAKE:  shift_n = shift_q | 2'b10;
			kbd_pkg::SC_LSHIFT_BREAK: shift_n = shift_q & 2'b10;
			kbd_pkg::SC_RSHIFT_BREAK: shift_n = shift_q & 2'b01;
			kbd_pkg::SC_CAPS:         lock_bit = kbd_pkg::LED_CAPS;
			kbd_pkg::SC_NUM:          lock_bit = kbd_pkg::LED_NUM;
			kbd_pkg::SC_SCROLL:       lock_bit = kbd_pkg::LED_SCROLL;
			default: ;
		endcase
	end

	assign leds_n   = leds_q ^ lock_bit;
	assign await_a  = (scancode == kbd_pkg::SC_ACK) ? 1'b0 : await_q;
	// resend with nothing pending is ignored
	assign resend_v = (scancode == kbd_pkg::SC_RESEND) && await_q;

	// a lock press queues 0xed and the mask; near full only 0xed fits,
	// when full both bytes are dropped
	assign push_pair   = (lock_bit != 3'b000) && (cnt_q <= CNT_PAIR_MAX);
	assign push_single = (lock_bit != 3'b000) && (cnt_q == CNT_SINGLE);
	assign qwe         = accept && (push_pair || push_single);
	assign qwd         = '{has_mask: push_pair, mask: leds_n};
	assign cnt_a       = cnt_q + (push_pair   ? kbd_pkg::QCNT_W'(2) :
	                              push_single ? kbd_pkg::QCNT_W'(1) : '0);

	// pop after push: an empty queue hands its new entry straight through
	assign pop_v    = !await_a && (cnt_a != '0);
	assign head     = (cnt_q == '0) ? qwd : head_q;
	assign pop_byte = half_q ? {5'b00000, head.mask} : kbd_pkg::LED_CMD;
	assign pop_adv  = half_q || !head.has_mask;

	assign rp_inc  = (rp_q == PTR_LAST) ? '0 : rp_q + kbd_pkg::QPTR_W'(1);
	assign wp_inc  = (wp_q == PTR_LAST) ? '0 : wp_q + kbd_pkg::QPTR_W'(1);
	assign rp_n    = (accept && pop_v && pop_adv) ? rp_inc : rp_q;
	assign rd_addr = rp_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 2'b00;
			leds_q  <= 3'b000;
			await_q <= 1'b0;
			held_q  <= 8'h00;
			rp_q    <= '0;
			wp_q    <= '0;
			cnt_q   <= '0;
			half_q  <= 1'b0;
		end else if (accept) begin
			shift_q <= shift_n;
			leds_q  <= leds_n;
			rp_q    <= rp_n;
			if (qwe) begin
				wp_q <= wp_inc;
			end
			if (pop_v) begin
				await_q <= 1'b1;
				held_q  <= pop_byte;
				cnt_q   <= cnt_a - kbd_pkg::QCNT_W'(1);
				half_q  <= !pop_adv;
			end else begin
				await_q <= await_a;
				cnt_q   <= cnt_a;
			end
		end
	end

	// queue memory, read through the registered head; a write to the address being
	// prefetched is forwarded into the head register
	always_ff @(posedge clk) begin
		if (qwe) begin
			qmem[wp_q] <= qwd;
		end
		if (qwe && (wp_q == rd_addr)) begin
			head_q <= qwd;
		end else begin
			head_q <= qmem[rd_addr];
		end
	end

	// at most two results: character or resend first, then the popped command
	assign r_first = '{kind:  resend_v ? kbd_pkg::KIND_CMD : kbd_pkg::KIND_CHAR,
	                   value: char_v ? ch : held_q,
	                   last:  !pop_v};
	assign r_pop   = '{kind: kbd_pkg::KIND_CMD, value: pop_byte, last: 1'b1};

	always_comb begin
		push.n  = 2'd0;
		push.r0 = r_first;
		push.r1 = r_pop;
		if (accept) begin
			if (char_v || resend_v) begin
				push.n = pop_v ? 2'd2 : 2'd1;
			end else if (pop_v) begin
				push.n  = 2'd1;
				push.r0 = r_pop;
			end
		end
	end

	kbd_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.busy      (fifo_busy),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	assign kind  = res.kind;
	assign value = res.value;
	assign last  = res.last;

endmodule

### rtl/kbd_checker.sv
// port-level assertions for the scancode decoder, bound to its top level
// depends on keyboard_scancode_decoder and kbd_pkg
module kbd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       scan_valid,
	input logic       scan_stall,
	input logic [7:0] scancode,
	input logic       res_valid,
	input logic       res_stall,
	input logic       kind,
	input logic [7:0] value,
	input logic       last
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(kind) && $stable(value)
		&& $stable(last))
		else $error("stalled result changed");

	// input is only held back while results are waiting
	a_stall_has_res: assert property (@(posedge clk) disable iff (!arst_n)
		scan_stall |-> res_valid)
		else $error("input stalled with no result pending");

	// characters are never zero
	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == kbd_pkg::KIND_CHAR) |-> value != 8'h00)
		else $error("zero character emitted");

	// a character that is not last is followed at once by a command byte
	a_char_then_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && (kind == kbd_pkg::KIND_CHAR) && !last
		|=> res_valid && (kind == kbd_pkg::KIND_CMD) && last)
		else $error("second result of an item missing");

endmodule

bind keyboard_scancode_decoder kbd_checker u_kbd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.scan_valid (scan_valid),
	.scan_stall (scan_stall),
	.scancode   (scancode),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.kind       (kind),
	.value      (value),
	.last       (last)
);
